// ----- rtl/text_console_character_engine_assert.svh -----
// Assertion macros used by the checker of the text console character engine.
`ifndef TEXT_CONSOLE_CHARACTER_ENGINE_ASSERT_SVH
`define TEXT_CONSOLE_CHARACTER_ENGINE_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent, outside reset.
`define TCCE_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent, outside reset.
`define TCCE_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent, reset included.
`define TCCE_ASSERT_NEXT_ALWAYS(label, ante, cons, msg) \
  label: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- rtl/tcce_pkg.sv -----
// Types and constants shared by the text console character engine modules.
package tcce_pkg;

  localparam int POS_W  = 11;
  localparam int CELL_W = 16;
  localparam int IDX_W  = 11;
  localparam int QDEPTH = 2;

  localparam logic [1:0] ACT_PUT   = 2'd0;
  localparam logic [1:0] ACT_CLEAR = 2'd1;
  localparam logic [1:0] ACT_READ  = 2'd2;

  localparam logic [7:0] CHR_BS    = 8'h08;
  localparam logic [7:0] CHR_TAB   = 8'h09;
  localparam logic [7:0] CHR_LF    = 8'h0A;
  localparam logic [7:0] CHR_CR    = 8'h0D;
  localparam logic [7:0] CHR_FIRST = 8'h20;
  localparam logic [7:0] CHR_LAST  = 8'h7F;

  localparam logic [CELL_W-1:0] BLANK_CELL = 16'h0F20;

  localparam logic [2:0] OP_NOP   = 3'd0;
  localparam logic [2:0] OP_PRINT = 3'd1;
  localparam logic [2:0] OP_BS    = 3'd2;
  localparam logic [2:0] OP_TAB   = 3'd3;
  localparam logic [2:0] OP_CR    = 3'd4;
  localparam logic [2:0] OP_LF    = 3'd5;
  localparam logic [2:0] OP_CLEAR = 3'd6;
  localparam logic [2:0] OP_READ  = 3'd7;

  typedef struct packed {
    logic [1:0]       action;
    logic [7:0]       char_code;
    logic [3:0]       bg_nibble;
    logic [3:0]       fg_nibble;
    logic [IDX_W-1:0] read_index;
  } in_item_t;

  typedef struct packed {
    logic [POS_W-1:0]  cursor_position;
    logic [CELL_W-1:0] cell_data;
  } out_item_t;

  typedef struct packed {
    logic [2:0]        op;
    logic [CELL_W-1:0] cell_word;
    logic [IDX_W-1:0]  index;
  } cmd_t;

  typedef struct packed {
    logic valid;
    cmd_t cmd;
  } cmd_req_t;

  typedef struct packed {
    logic init_busy;
  } back_stat_t;

endpackage

// ----- rtl/tcce_front.sv -----
// Front end: accepts transactions and classifies them into commands for the queue.
module tcce_front #(
  parameter int COLUMNS = 80,
  parameter int ROWS    = 25
) (
  input  logic               start,
  input  logic               busy,
  input  tcce_pkg::in_item_t in_item,
  output tcce_pkg::cmd_req_t push
);
  import tcce_pkg::*;

  localparam int CELLS = COLUMNS * ROWS;
  localparam int CMPW  = $clog2(CELLS + 1) + IDX_W;

  logic [2:0] op;
  logic       in_range;

  assign in_range = CMPW'(in_item.read_index) < CMPW'(CELLS);

  always_comb begin
    op = OP_NOP;
    case (in_item.action)
      ACT_PUT: begin
        if (in_item.char_code == CHR_BS) begin
          op = OP_BS;
        end else if (in_item.char_code == CHR_TAB) begin
          op = OP_TAB;
        end else if (in_item.char_code == CHR_CR) begin
          op = OP_CR;
        end else if (in_item.char_code == CHR_LF) begin
          op = OP_LF;
        end else if (in_item.char_code >= CHR_FIRST && in_item.char_code <= CHR_LAST) begin
          op = OP_PRINT;
        end
      end
      ACT_CLEAR: begin
        op = OP_CLEAR;
      end
      ACT_READ: begin
        if (in_range) begin
          op = OP_READ;
        end
      end
      default: begin
        op = OP_NOP;
      end
    endcase
  end

  assign push.valid         = start && !busy;
  assign push.cmd.op        = op;
  assign push.cmd.cell_word = {in_item.bg_nibble, in_item.fg_nibble, in_item.char_code};
  assign push.cmd.index     = in_item.read_index;

endmodule

// ----- rtl/tcce_queue.sv -----
// Short command queue between the front end and the back end.
module tcce_queue (
  input  logic               clk,
  input  logic               rst_n,
  input  tcce_pkg::cmd_req_t push,
  input  logic               pop,
  output tcce_pkg::cmd_req_t head,
  output logic               full
);
  import tcce_pkg::*;

  localparam int QAW = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
  localparam int QCW = $clog2(QDEPTH + 1);

  cmd_t           slot_r [QDEPTH];
  logic [QAW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [QAW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [QCW-1:0] count_r, count_nxt;
  logic           do_push, do_pop;

  assign full       = count_r == QCW'(QDEPTH);
  assign head.valid = count_r != '0;
  assign head.cmd   = slot_r[rd_ptr_r];
  assign do_push    = push.valid && !full;
  assign do_pop     = pop && head.valid;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == QAW'(QDEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == QAW'(QDEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (!do_push && do_pop) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      slot_r[wr_ptr_r] <= push.cmd;
    end
  end

endmodule

// ----- rtl/tcce_back.sv -----
// Back end: cursor logic, screen cell memory, clear and scroll sweeps, and results.
module tcce_back #(
  parameter int COLUMNS   = 80,
  parameter int ROWS      = 25,
  parameter int TAB_WIDTH = 8
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  tcce_pkg::cmd_req_t    head,
  output logic                  pop,
  output tcce_pkg::back_stat_t  stat,
  output logic                  out_strobe,
  output tcce_pkg::out_item_t   out_item
);
  import tcce_pkg::*;

  localparam int CELLS = COLUMNS * ROWS;
  localparam int AW    = $clog2(CELLS);
  localparam int SW    = $clog2(CELLS + 1);
  localparam int CW    = $clog2(COLUMNS);
  localparam int NW    = $clog2(COLUMNS + TAB_WIDTH);
  localparam int RW    = $clog2(ROWS);
  localparam int PHW   = $clog2(TAB_WIDTH);

  localparam logic [2:0] ST_INIT   = 3'd0;
  localparam logic [2:0] ST_IDLE   = 3'd1;
  localparam logic [2:0] ST_CLEAR  = 3'd2;
  localparam logic [2:0] ST_SCROLL = 3'd3;
  localparam logic [2:0] ST_RESP   = 3'd4;

  logic [CELL_W-1:0] screen_r [CELLS];
  logic [CELL_W-1:0] rdata_r;

  logic [2:0]     state_r, state_nxt;
  logic [SW-1:0]  sweep_r, sweep_nxt;
  logic [CW-1:0]  col_r, col_nxt;
  logic [RW-1:0]  row_r, row_nxt;
  logic [PHW-1:0] phase_r, phase_nxt;
  logic           rsp_read_r, rsp_read_nxt;
  logic           strobe_r, strobe_nxt;
  out_item_t      out_r, out_nxt;

  logic              wr_en, rd_en;
  logic [AW-1:0]     wr_addr, rd_addr;
  logic [CELL_W-1:0] wr_data;
  logic [AW-1:0]     pos;
  logic [NW-1:0]     col_t;
  logic [RW:0]       row_t;
  logic [PHW-1:0]    phase_t;
  logic [SW-1:0]     sweep_prev;

  assign pos        = AW'(AW'(row_r) * AW'(COLUMNS) + AW'(col_r));
  assign sweep_prev = sweep_r - SW'(1);

  always_comb begin
    state_nxt    = state_r;
    sweep_nxt    = sweep_r;
    col_nxt      = col_r;
    row_nxt      = row_r;
    phase_nxt    = phase_r;
    rsp_read_nxt = rsp_read_r;
    strobe_nxt   = 1'b0;
    out_nxt      = out_r;
    pop          = 1'b0;
    wr_en        = 1'b0;
    wr_addr      = '0;
    wr_data      = BLANK_CELL;
    rd_en        = 1'b0;
    rd_addr      = '0;
    col_t        = NW'(col_r);
    row_t        = (RW + 1)'(row_r);
    phase_t      = phase_r;
    case (state_r)
      ST_INIT, ST_CLEAR: begin
        wr_en   = 1'b1;
        wr_addr = sweep_r[AW-1:0];
        if (sweep_r == SW'(CELLS - 1)) begin
          sweep_nxt = '0;
          state_nxt = (state_r == ST_INIT) ? ST_IDLE : ST_RESP;
        end else begin
          sweep_nxt = sweep_r + 1'b1;
        end
      end
      ST_SCROLL: begin
        if (sweep_r < SW'(CELLS - COLUMNS)) begin
          rd_en   = 1'b1;
          rd_addr = AW'(sweep_r + SW'(COLUMNS));
        end
        if (sweep_r != '0) begin
          wr_en   = 1'b1;
          wr_addr = sweep_prev[AW-1:0];
          wr_data = (sweep_prev < SW'(CELLS - COLUMNS)) ? rdata_r : BLANK_CELL;
        end
        if (sweep_r == SW'(CELLS)) begin
          sweep_nxt = '0;
          state_nxt = ST_RESP;
        end else begin
          sweep_nxt = sweep_r + 1'b1;
        end
      end
      ST_RESP: begin
        strobe_nxt              = 1'b1;
        out_nxt.cursor_position = POS_W'(pos);
        out_nxt.cell_data       = rsp_read_r ? rdata_r : '0;
        state_nxt               = ST_IDLE;
      end
      ST_IDLE: begin
        if (head.valid) begin
          pop          = 1'b1;
          rsp_read_nxt = 1'b0;
          state_nxt    = ST_RESP;
          case (head.cmd.op)
            OP_CLEAR: begin
              col_nxt   = '0;
              row_nxt   = '0;
              phase_nxt = '0;
              sweep_nxt = '0;
              state_nxt = ST_CLEAR;
            end
            OP_READ: begin
              rd_en        = 1'b1;
              rd_addr      = AW'(head.cmd.index);
              rsp_read_nxt = 1'b1;
            end
            OP_NOP: begin
              state_nxt = ST_RESP;
            end
            default: begin
              case (head.cmd.op)
                OP_BS: begin
                  if (col_r != '0) begin
                    col_t   = NW'(col_r) - NW'(1);
                    phase_t = (phase_r == '0) ? PHW'(TAB_WIDTH - 1) : phase_r - 1'b1;
                  end
                end
                OP_TAB: begin
                  col_t   = NW'(col_r) + NW'(TAB_WIDTH) - NW'(phase_r);
                  phase_t = '0;
                end
                OP_CR: begin
                  col_t   = '0;
                  phase_t = '0;
                end
                OP_LF: begin
                  col_t   = '0;
                  phase_t = '0;
                  row_t   = (RW + 1)'(row_r) + 1'b1;
                end
                default: begin
                  wr_en   = 1'b1;
                  wr_addr = pos;
                  wr_data = head.cmd.cell_word;
                  col_t   = NW'(col_r) + NW'(1);
                  phase_t = (phase_r == PHW'(TAB_WIDTH - 1)) ? '0 : phase_r + 1'b1;
                end
              endcase
              if (col_t >= NW'(COLUMNS)) begin
                col_t   = '0;
                phase_t = '0;
                row_t   = row_t + 1'b1;
              end
              col_nxt   = CW'(col_t);
              phase_nxt = phase_t;
              if (row_t >= (RW + 1)'(ROWS)) begin
                row_nxt   = RW'(ROWS - 1);
                sweep_nxt = '0;
                state_nxt = ST_SCROLL;
              end else begin
                row_nxt = RW'(row_t);
              end
            end
          endcase
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= ST_INIT;
      sweep_r    <= '0;
      col_r      <= '0;
      row_r      <= '0;
      phase_r    <= '0;
      rsp_read_r <= 1'b0;
      strobe_r   <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      sweep_r    <= sweep_nxt;
      col_r      <= col_nxt;
      row_r      <= row_nxt;
      phase_r    <= phase_nxt;
      rsp_read_r <= rsp_read_nxt;
      strobe_r   <= strobe_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_r <= out_nxt;
    if (wr_en) begin
      screen_r[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rdata_r <= screen_r[rd_addr];
    end
  end

  assign stat.init_busy = state_r == ST_INIT;
  assign out_strobe     = strobe_r;
  assign out_item       = out_r;

endmodule

// ----- rtl/text_console_character_engine.sv -----
// Top level of the text console character engine.
//
//   Channel  Handshake                      Payload
//   in_      start high, busy low at edge   in_item (action, char, colors, read index)
//   out_     out_strobe high for one cycle  out_item (cursor position, cell data)
//
// With the back end idle, a command passes through the two-entry queue and the back end's
// response state before the registered result strobes, one command at a time.
// A clear or a scroll sweeps the screen memory first, one cell per cycle through its
// single write port.
// After reset the memory is blanked while busy stays high.
// Busy also rises when the queue is full; the receiver cannot stall results.
module text_console_character_engine #(
  parameter int COLUMNS   = 80,
  parameter int ROWS      = 25,
  parameter int TAB_WIDTH = 8
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  output logic                busy,
  input  tcce_pkg::in_item_t  in_item,
  output logic                out_strobe,
  output tcce_pkg::out_item_t out_item
);
  import tcce_pkg::*;

  cmd_req_t   push, head;
  logic       pop, full;
  back_stat_t stat;

  assign busy = full || stat.init_busy;

  tcce_front #(
    .COLUMNS (COLUMNS),
    .ROWS    (ROWS)
  ) u_front (
    .start   (start),
    .busy    (busy),
    .in_item (in_item),
    .push    (push)
  );

  tcce_queue u_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (push),
    .pop   (pop),
    .head  (head),
    .full  (full)
  );

  tcce_back #(
    .COLUMNS   (COLUMNS),
    .ROWS      (ROWS),
    .TAB_WIDTH (TAB_WIDTH)
  ) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .head       (head),
    .pop        (pop),
    .stat       (stat),
    .out_strobe (out_strobe),
    .out_item   (out_item)
  );

endmodule

// ----- rtl/tcce_checker.sv -----
// Port-level assertions for the text console character engine and their bind.
`include "text_console_character_engine_assert.svh"

module tcce_checker #(
  parameter int COLUMNS = 80,
  parameter int ROWS    = 25
) (
  input logic                clk,
  input logic                rst_n,
  input logic                busy,
  input logic                out_strobe,
  input tcce_pkg::out_item_t out_item
);
  import tcce_pkg::*;

  localparam int  CELLS   = COLUMNS * ROWS;
  localparam bit  POS_FIT = CELLS <= (1 << POS_W);

  logic cursor_on_screen;

  assign cursor_on_screen = 32'(out_item.cursor_position) < 32'(CELLS);

  `TCCE_ASSERT_NEXT_ALWAYS(a_busy_after_reset, !rst_n, busy, "busy low after reset")
  `TCCE_ASSERT_NEXT(a_strobe_single, out_strobe, !out_strobe, "strobes in adjacent cycles")
  `TCCE_ASSERT_NOW(a_cursor_range, out_strobe && POS_FIT, cursor_on_screen, "cursor off screen")

endmodule

bind text_console_character_engine tcce_checker #(
  .COLUMNS (COLUMNS),
  .ROWS    (ROWS)
) u_tcce_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .busy       (busy),
  .out_strobe (out_strobe),
  .out_item   (out_item)
);

// ----- tb/text_console_character_engine_test.sv -----
// Self-checking testbench for the text console character engine, predicting every result.
module text_console_character_engine_test;
  timeunit 1ns;
  timeprecision 1ps;
  import tcce_pkg::*;

  localparam int COLUMNS = 80;
  localparam int ROWS = 25;
  localparam int TAB_WIDTH = 8;
  localparam int CELL_COUNT = COLUMNS * ROWS;
  localparam logic [1:0] ACT_UNUSED = 2'd3;
  localparam int CYCLE_LIMIT = 3_000_000;
  localparam int DRAIN_CYCLES = 100;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic start = 1'b0;
  logic busy;
  in_item_t in_item = '0;
  logic out_strobe;
  out_item_t out_item;

  in_item_t pending_items[$];
  out_item_t expected_results[$];
  logic [CELL_W-1:0] screen_model [CELL_COUNT];
  int unsigned model_column = 0;
  int unsigned model_row = 0;
  int unsigned idle_percent = 0;
  int unsigned error_count = 0;
  int unsigned cycle_count = 0;
  logic taken = 1'b0;

  text_console_character_engine #(
    .COLUMNS(COLUMNS),
    .ROWS(ROWS),
    .TAB_WIDTH(TAB_WIDTH)
  ) i_dut (
    .clk(clk),
    .rst_n(rst_n),
    .start(start),
    .busy(busy),
    .in_item(in_item),
    .out_strobe(out_strobe),
    .out_item(out_item)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  function automatic void blank_screen_model();
    for (int i = 0; i < CELL_COUNT; i++) begin
      screen_model[i] = BLANK_CELL;
    end
    model_column = 0;
    model_row = 0;
  endfunction

  function automatic out_item_t console_step(in_item_t item);
    out_item_t result;
    logic [7:0] code;
    result = '0;
    code = item.char_code;
    case (item.action)
      ACT_PUT: begin
        if (code == CHR_BS) begin
          if (model_column > 0) begin
            model_column--;
          end
        end else if (code == CHR_TAB) begin
          model_column = model_column + TAB_WIDTH - model_column % TAB_WIDTH;
        end else if (code == CHR_CR) begin
          model_column = 0;
        end else if (code == CHR_LF) begin
          model_column = 0;
          model_row++;
        end else if (code >= CHR_FIRST && code <= CHR_LAST) begin
          screen_model[model_row * COLUMNS + model_column] =
            {item.bg_nibble, item.fg_nibble, code};
          model_column++;
        end
        if (model_column >= COLUMNS) begin
          model_column = 0;
          model_row++;
        end
        if (model_row >= ROWS) begin
          for (int i = 0; i < (ROWS - 1) * COLUMNS; i++) begin
            screen_model[i] = screen_model[i + COLUMNS];
          end
          for (int i = (ROWS - 1) * COLUMNS; i < CELL_COUNT; i++) begin
            screen_model[i] = BLANK_CELL;
          end
          model_row = ROWS - 1;
        end
      end
      ACT_CLEAR: begin
        blank_screen_model();
      end
      ACT_READ: begin
        if (item.read_index < CELL_COUNT) begin
          result.cell_data = screen_model[item.read_index];
        end
      end
      default: begin
      end
    endcase
    result.cursor_position = POS_W'(model_row * COLUMNS + model_column);
    return result;
  endfunction

  task automatic report_mismatch(string what);
    $display("MISMATCH at %0t ns: %s", $time, what);
    error_count++;
  endtask

  task automatic add_item(logic [1:0] action, logic [7:0] code, logic [3:0] back,
                          logic [3:0] fore, logic [IDX_W-1:0] index);
    in_item_t item;
    item.action = action;
    item.char_code = code;
    item.bg_nibble = back;
    item.fg_nibble = fore;
    item.read_index = index;
    pending_items.push_back(item);
  endtask

  task automatic add_put(logic [7:0] code);
    add_item(ACT_PUT, code, 4'($urandom), 4'($urandom), IDX_W'($urandom));
  endtask

  task automatic add_other(logic [1:0] action, logic [IDX_W-1:0] index);
    add_item(action, 8'($urandom), 4'($urandom), 4'($urandom), index);
  endtask

  task automatic wait_drained();
    do begin
      @(negedge clk);
    end while (pending_items.size() != 0 || start || expected_results.size() != 0);
  endtask

  task automatic queue_random_text(int count);
    int added;
    int len;
    int pick;
    added = 0;
    while (added < count) begin
      pick = $urandom_range(299);
      if (pick == 0) begin
        add_other(ACT_CLEAR, IDX_W'($urandom));
        added++;
      end else if (pick < 170) begin
        len = $urandom_range(8);
        repeat (len) begin
          pick = $urandom_range(19);
          if (pick == 0) begin
            add_put(CHR_BS);
          end else if (pick == 1) begin
            add_put(CHR_TAB);
          end else begin
            add_put(8'($urandom_range(CHR_FIRST, CHR_LAST)));
          end
        end
        added += len;
        pick = $urandom_range(9);
        if (pick < 2) begin
          add_put(CHR_CR);
          add_put(CHR_LF);
          added += 2;
        end else if (pick < 3) begin
          add_put(CHR_CR);
          added++;
        end else if (pick < 9) begin
          add_put(CHR_LF);
          added++;
        end
      end else if (pick < 225) begin
        pick = $urandom_range(2);
        if (pick == 0) begin
          add_other(ACT_READ, IDX_W'($urandom));
        end else if (pick == 1) begin
          add_other(ACT_READ, IDX_W'($urandom_range(CELL_COUNT - 2 * COLUMNS, CELL_COUNT - 1)));
        end else begin
          add_other(ACT_READ, IDX_W'($urandom_range(CELL_COUNT - 1)));
        end
        added++;
      end else if (pick < 260) begin
        add_put(8'($urandom));
        added++;
      end else if (pick < 270) begin
        add_other(ACT_UNUSED, IDX_W'($urandom));
        added++;
      end else begin
        len = $urandom_range(3, 10);
        repeat (len) add_put(CHR_TAB);
        added += len;
      end
    end
  endtask

  always @(negedge clk) begin
    if (!rst_n) begin
      start <= 1'b0;
    end else if (!start || taken) begin
      if (pending_items.size() > 0 && $urandom_range(99) >= idle_percent) begin
        in_item <= pending_items.pop_front();
        start <= 1'b1;
      end else begin
        start <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    out_item_t want;
    if (rst_n) begin
      if (out_strobe === 1'b1) begin
        if (expected_results.size() == 0) begin
          report_mismatch("result strobe with no transaction outstanding");
        end else begin
          want = expected_results.pop_front();
          if (out_item.cursor_position !== want.cursor_position) begin
            report_mismatch($sformatf("cursor_position got %0d expected %0d",
                                      out_item.cursor_position, want.cursor_position));
          end
          if (out_item.cell_data !== want.cell_data) begin
            report_mismatch($sformatf("cell_data got %h expected %h",
                                      out_item.cell_data, want.cell_data));
          end
        end
      end
      if (start && busy === 1'b0) begin
        expected_results.push_back(console_step(in_item));
      end
      taken <= start && busy === 1'b0;
    end
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  initial begin
    blank_screen_model();
    repeat (2) @(negedge clk);
    rst_n <= 1'b1;

    add_other(ACT_READ, IDX_W'(CELL_COUNT));
    add_other(ACT_READ, '1);
    add_put(CHR_BS);
    add_item(ACT_PUT, CHR_FIRST, 4'h0, 4'h0, '0);
    add_item(ACT_PUT, CHR_LAST, 4'hF, 4'hF, '1);
    add_put(8'h00);
    add_put(8'h80);
    add_put(8'hFF);
    add_other(ACT_UNUSED, IDX_W'($urandom));
    add_put(CHR_BS);
    add_put(CHR_TAB);
    add_put(CHR_CR);
    add_put(CHR_LF);
    repeat (10) add_put(CHR_TAB);
    add_other(ACT_READ, '0);
    add_other(ACT_READ, IDX_W'(1));
    add_other(ACT_READ, IDX_W'(CELL_COUNT - 1));
    add_other(ACT_CLEAR, IDX_W'($urandom));
    add_other(ACT_READ, IDX_W'(1));
    wait_drained();

    idle_percent = 0;
    queue_random_text(90);
    wait_drained();
    idle_percent = 88;
    queue_random_text(85);
    wait_drained();
    idle_percent = 19;
    queue_random_text(90);
    wait_drained();

    repeat (DRAIN_CYCLES) @(posedge clk);
    if (error_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
